### rtl/core/http_cookie_header_tokenizer_unit_assert.svh
// assertion helpers for the cookie header tokenizer
// both expect clk_i and rst_ni in scope
`ifndef HTTP_COOKIE_HEADER_TOKENIZER_UNIT_ASSERT_SVH
`define HTTP_COOKIE_HEADER_TOKENIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define HCTOK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HCTOK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/hctok_pkg.sv
`default_nettype none

package hctok_pkg;

  typedef enum logic [2:0] {
    PH_PRE_NAME   = 3'd0,
    PH_NAME       = 3'd1,
    PH_POST_NAME  = 3'd2,
    PH_PRE_VALUE  = 3'd3,
    PH_VALUE      = 3'd4,
    PH_POST_VALUE = 3'd5,
    PH_ERROR      = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KIND_PLAIN   = 3'd0,
    KIND_VERSION = 3'd1,
    KIND_PATH    = 3'd2,
    KIND_DOMAIN  = 3'd3,
    KIND_PORT    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ROLE_DROP  = 2'd0,
    ROLE_NAME  = 2'd1,
    ROLE_VALUE = 2'd2
  } role_e;

  typedef enum logic [1:0] {
    KW_VERSION = 2'd0,
    KW_PATH    = 2'd1,
    KW_DOMAIN  = 2'd2,
    KW_PORT    = 2'd3
  } kw_e;

  typedef enum logic [1:0] {
    VM_NONE  = 2'd0,
    VM_ONE   = 2'd1,
    VM_OTHER = 2'd2
  } vmatch_e;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_ONE   = 8'd49;
  localparam logic [7:0] CH_SEMI  = 8'd59;
  localparam logic [7:0] CH_EQ    = 8'd61;
  localparam logic [7:0] CH_MAX   = 8'd126;
  localparam logic [3:0] POS_MAX  = 4'd15;
  localparam int unsigned NUM_KW  = 4;

  typedef struct packed {
    logic invalid;
    logic ws;
    logic token;
    logic eq;
    logic quote;
    logic semi;
    logic comma;
    logic one;
  } class_t;

  typedef struct packed {
    phase_e              phase;
    logic                first_pair;
    logic                cookie2;
    logic                in_quotes;
    kind_e               attr_kind;
    logic                have_name;
    logic [3:0]          kw_pos;
    logic [NUM_KW-1:0]   kw_alive;
    vmatch_e             ver_match;
    logic                name_nonempty;
    logic                err;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:         PH_PRE_NAME,
    first_pair:    1'b1,
    cookie2:       1'b0,
    in_quotes:     1'b0,
    attr_kind:     KIND_PLAIN,
    have_name:     1'b0,
    kw_pos:        4'd0,
    kw_alive:      {NUM_KW{1'b1}},
    ver_match:     VM_NONE,
    name_nonempty: 1'b0,
    err:           1'b0
  };

  typedef struct packed {
    logic [7:0] out_byte;
    role_e      role;
    logic       name_end;
    kind_e      name_kind;
    logic       value_end;
    logic       cookie_done;
    logic       parse_error;
    logic       finished;
    logic       header_ok;
  } result_t;

  function automatic logic [3:0] kw_len(input kw_e k);
    logic [3:0] len;
    case (k)
      KW_VERSION: len = 4'd8;
      KW_PATH:    len = 4'd5;
      KW_DOMAIN:  len = 4'd7;
      KW_PORT:    len = 4'd5;
      default:    len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input kw_e k, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      KW_VERSION: begin
        case (pos)
          3'd0: c = "$";
          3'd1: c = "V";
          3'd2: c = "e";
          3'd3: c = "r";
          3'd4: c = "s";
          3'd5: c = "i";
          3'd6: c = "o";
          3'd7: c = "n";
          default: c = 8'h00;
        endcase
      end
      KW_PATH: begin
        case (pos)
          3'd0: c = "$";
          3'd1: c = "P";
          3'd2: c = "a";
          3'd3: c = "t";
          3'd4: c = "h";
          default: c = 8'h00;
        endcase
      end
      KW_DOMAIN: begin
        case (pos)
          3'd0: c = "$";
          3'd1: c = "D";
          3'd2: c = "o";
          3'd3: c = "m";
          3'd4: c = "a";
          3'd5: c = "i";
          3'd6: c = "n";
          default: c = 8'h00;
        endcase
      end
      KW_PORT: begin
        case (pos)
          3'd0: c = "$";
          3'd1: c = "P";
          3'd2: c = "o";
          3'd3: c = "r";
          3'd4: c = "t";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/hctok_class.sv
`default_nettype none

module hctok_class (
  input  wire logic [7:0]      byte_i,
  output hctok_pkg::class_t    class_o
);
  import hctok_pkg::*;

  logic sep;

  // separator set, question mark included
  always_comb begin
    case (byte_i)
      8'd34, 8'd40, 8'd41, 8'd44, 8'd47, 8'd58, 8'd59, 8'd60,
      8'd61, 8'd62, 8'd63, 8'd64, 8'd91, 8'd92, 8'd93, 8'd123,
      8'd125: sep = 1'b1;
      default: sep = 1'b0;
    endcase
  end

  always_comb begin
    class_o.invalid = (byte_i == 8'd0) || (byte_i > CH_MAX);
    class_o.ws      = (byte_i == CH_SPACE) || (byte_i == CH_TAB);
    class_o.token   = (byte_i > CH_SPACE) && (byte_i <= CH_MAX) && !sep;
    class_o.eq      = (byte_i == CH_EQ);
    class_o.quote   = (byte_i == CH_QUOTE);
    class_o.semi    = (byte_i == CH_SEMI);
    class_o.comma   = (byte_i == CH_COMMA);
    class_o.one     = (byte_i == CH_ONE);
  end

endmodule

`default_nettype wire

### rtl/core/hctok_step.sv
`default_nettype none

module hctok_step (
  input  wire hctok_pkg::state_t  state_i,
  input  wire logic [7:0]         byte_i,
  input  wire logic               last_i,
  input  wire hctok_pkg::class_t  class_i,
  output hctok_pkg::state_t       state_o,
  output hctok_pkg::result_t      result_o
);
  import hctok_pkg::*;

  logic [NUM_KW-1:0] kw_hit;
  logic [NUM_KW-1:0] kw_alive_fed;

  // decisions for this byte
  logic    bad;
  role_e   role;
  logic    nend;
  kind_e   kind;
  logic    vend;
  phase_e  ph_n;
  logic    feed_nm;
  logic    feed_vl;
  logic    rst_nm;
  logic    q_set;
  logic    q_clr;
  logic    fp_clr;
  logic    c2_set;
  logic    vm_clr;
  logic    ver_bad;
  logic    sep;

  state_t  st_m;
  logic    at_value_end;
  logic    err_fin;

  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      kw_hit[k] = state_i.kw_alive[k] && (state_i.kw_pos == kw_len(kw_e'(k)));
      kw_alive_fed[k] = state_i.kw_alive[k] && (state_i.kw_pos < kw_len(kw_e'(k)))
                        && (kw_char(kw_e'(k), state_i.kw_pos[2:0]) == byte_i);
    end
  end

  assign ver_bad = (state_i.attr_kind == KIND_VERSION) && (state_i.ver_match != VM_ONE);
  assign sep     = class_i.semi || (class_i.comma && state_i.first_pair);

  // phase transition and per-byte actions
  always_comb begin
    bad     = 1'b0;
    role    = ROLE_DROP;
    nend    = 1'b0;
    kind    = KIND_PLAIN;
    vend    = 1'b0;
    ph_n    = state_i.phase;
    feed_nm = 1'b0;
    feed_vl = 1'b0;
    rst_nm  = 1'b0;
    q_set   = 1'b0;
    q_clr   = 1'b0;
    fp_clr  = 1'b0;
    c2_set  = 1'b0;
    vm_clr  = 1'b0;
    // the unused phase code behaves as the error phase
    if ((state_i.phase == PH_ERROR) || (state_i.phase > PH_POST_VALUE)) begin
      ph_n = PH_ERROR;
    end else if (class_i.invalid) begin
      bad = 1'b1;
    end else begin
      case (state_i.phase)
        PH_PRE_NAME: begin
          if (class_i.ws) begin
            ph_n = PH_NAME;
          end else if (class_i.token) begin
            feed_nm = 1'b1;
            role    = ROLE_NAME;
            ph_n    = PH_NAME;
          end else begin
            bad = 1'b1;
          end
        end
        PH_NAME: begin
          if (class_i.eq || class_i.ws) begin
            if (!state_i.name_nonempty) begin
              bad = 1'b1;
            end else begin
              if (state_i.first_pair && kw_hit[KW_VERSION]) begin
                kind = KIND_VERSION;
              end else if (state_i.cookie2 && kw_hit[KW_PATH]) begin
                kind = KIND_PATH;
              end else if (state_i.cookie2 && kw_hit[KW_DOMAIN]) begin
                kind = KIND_DOMAIN;
              end else if (state_i.cookie2 && kw_hit[KW_PORT]) begin
                kind = KIND_PORT;
              end
              c2_set = (kind == KIND_VERSION);
              nend   = 1'b1;
              rst_nm = 1'b1;
              vm_clr = 1'b1;
              ph_n   = class_i.eq ? PH_PRE_VALUE : PH_POST_NAME;
            end
          end else if (class_i.token) begin
            feed_nm = 1'b1;
            role    = ROLE_NAME;
          end else begin
            bad = 1'b1;
          end
        end
        PH_POST_NAME: begin
          if (class_i.eq) begin
            ph_n = PH_PRE_VALUE;
          end else if (!class_i.ws) begin
            bad = 1'b1;
          end
        end
        PH_PRE_VALUE: begin
          if (class_i.ws) begin
            ph_n = PH_PRE_VALUE;
          end else if (class_i.quote) begin
            q_set = 1'b1;
            ph_n  = PH_VALUE;
          end else if (class_i.token) begin
            feed_vl = 1'b1;
            role    = ROLE_VALUE;
            ph_n    = PH_VALUE;
          end else begin
            bad = 1'b1;
          end
        end
        PH_VALUE: begin
          if (state_i.in_quotes) begin
            if (class_i.quote) begin
              q_clr = 1'b1;
              vend  = 1'b1;
              if (ver_bad) bad = 1'b1;
              else ph_n = PH_POST_VALUE;
            end else begin
              // quoted bytes are kept, control bytes other than NUL and DEL included
              feed_vl = 1'b1;
              role    = ROLE_VALUE;
            end
          end else if (sep || class_i.ws) begin
            vend = 1'b1;
            if (ver_bad) begin
              bad = 1'b1;
            end else if (sep) begin
              fp_clr = 1'b1;
              rst_nm = 1'b1;
              ph_n   = PH_PRE_NAME;
            end else begin
              ph_n = PH_POST_VALUE;
            end
          end else if (class_i.token) begin
            feed_vl = 1'b1;
            role    = ROLE_VALUE;
          end else begin
            bad = 1'b1;
          end
        end
        PH_POST_VALUE: begin
          if (sep) begin
            fp_clr = 1'b1;
            rst_nm = 1'b1;
            ph_n   = PH_PRE_NAME;
          end else if (!class_i.ws) begin
            bad = 1'b1;
          end
        end
        default: begin
          ph_n = PH_ERROR;
        end
      endcase
    end
    if (bad) begin
      role = ROLE_DROP;
      ph_n = PH_ERROR;
    end
  end

  // next state
  always_comb begin
    st_m       = state_i;
    st_m.phase = ph_n;
    if (feed_nm) begin
      st_m.kw_alive      = kw_alive_fed;
      st_m.kw_pos        = (state_i.kw_pos == POS_MAX) ? POS_MAX : state_i.kw_pos + 4'd1;
      st_m.name_nonempty = 1'b1;
    end
    if (rst_nm) begin
      st_m.kw_pos        = 4'd0;
      st_m.kw_alive      = {NUM_KW{1'b1}};
      st_m.name_nonempty = 1'b0;
    end
    if (feed_vl) begin
      st_m.ver_match = (state_i.ver_match == VM_NONE && class_i.one) ? VM_ONE : VM_OTHER;
    end
    if (vm_clr) st_m.ver_match = VM_NONE;
    if (nend) begin
      st_m.attr_kind = kind;
      if (kind == KIND_PLAIN) st_m.have_name = 1'b1;
    end
    if (c2_set) st_m.cookie2 = 1'b1;
    if (fp_clr) st_m.first_pair = 1'b0;
    if (q_set) st_m.in_quotes = 1'b1;
    if (q_clr || bad) st_m.in_quotes = 1'b0;
    if (bad) st_m.err = 1'b1;
    state_o = last_i ? STATE_RESET : st_m;
  end

  // an unquoted value still open at the header end closes here
  assign at_value_end = last_i && (st_m.phase == PH_VALUE) && !st_m.in_quotes;
  assign err_fin = st_m.err || (at_value_end && (st_m.attr_kind == KIND_VERSION)
                                && (st_m.ver_match != VM_ONE));

  // result fields
  always_comb begin
    result_o.out_byte    = byte_i;
    result_o.role        = role;
    result_o.name_end    = nend;
    result_o.name_kind   = kind;
    result_o.value_end   = vend || at_value_end;
    result_o.cookie_done = (nend && (kind == KIND_PLAIN) && state_i.have_name)
                           || (last_i && st_m.have_name
                               && ((st_m.phase == PH_POST_VALUE)
                                   || (at_value_end && !err_fin)));
    result_o.parse_error = err_fin;
    result_o.finished    = last_i;
    result_o.header_ok   = last_i && !err_fin
                           && ((st_m.phase == PH_POST_VALUE)
                               || (at_value_end && st_m.have_name));
  end

endmodule

`default_nettype wire

### rtl/core/http_cookie_header_tokenizer_unit.sv
// an accepted byte passes the byte register, then the result register on the master side
// throughput: one byte per cycle; the byte register and the result register
// each take a new transaction whenever the stage after them moves
// while a result waits on m_axis_tready one more byte is held, then
// s_axis_tready stays low until the result moves; reset: rst_ni clears both
// valid flags asynchronously and returns the parser state to the header start
`default_nettype none
`include "http_cookie_header_tokenizer_unit_assert.svh"

module http_cookie_header_tokenizer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,   // in_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [8] name_end, [9] value_end,
                                           // [10] cookie_done, [11] parse_error,
                                           // [12] header_ok, [15:13] zero
  output logic [4:0]       m_axis_tuser,   // [1:0] byte_role, [4:2] name_kind
  output logic             m_axis_tlast    // finished
);
  import hctok_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  result_t    res_q;
  result_t    res_d;
  state_t     state_q;
  state_t     state_d;
  class_t     byte_class;
  logic       advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  hctok_class u_class (
    .byte_i  (in_byte_q),
    .class_o (byte_class)
  );

  hctok_step u_step (
    .state_i  (state_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .class_i  (byte_class),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) state_q <= state_d;
      if (advance) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.header_ok, res_q.parse_error, res_q.cookie_done,
                          res_q.value_end, res_q.name_end, res_q.out_byte};
  assign m_axis_tuser  = {res_q.name_kind, res_q.role};
  assign m_axis_tlast  = res_q.finished;

  `HCTOK_ASSERT_NOW(a_err_means_error_phase, 1'b1, state_q.err == (state_q.phase == PH_ERROR), "sticky error and error phase disagree")
  `HCTOK_ASSERT_NOW(a_quotes_only_in_value, state_q.in_quotes, state_q.phase == PH_VALUE, "quote flag set outside value phase")
  `HCTOK_ASSERT_NEXT(a_last_restarts, advance && in_last_q, state_q == STATE_RESET, "parser not back at start after final byte")
  `HCTOK_ASSERT_NEXT(a_result_follows, advance, out_valid_q && (res_q.out_byte == $past(in_byte_q)), "processed byte missing from result register")

endmodule

`default_nettype wire
